// ----- hw/rtl/sls_attenuation_memory_update_defines.svh -----
// assertion macros for the attenuation memory block
`ifndef SLS_ATTENUATION_MEMORY_UPDATE_DEFINES_SVH
`define SLS_ATTENUATION_MEMORY_UPDATE_DEFINES_SVH
`ifndef SYNTHESIS
`define SLSAM_ASSERT_IMPL(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("slsam assertion failed");
`define SLSAM_ASSERT_NEXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("slsam assertion failed");
`else
`define SLSAM_ASSERT_IMPL(name, clk, rst, pre, post)
`define SLSAM_ASSERT_NEXT(name, clk, rst, pre, post)
`endif
`endif

// ----- hw/rtl/slsam_pkg.sv -----
`timescale 1ns / 1ps
package slsam_pkg;
  localparam int DEF_SLOTS = 1024;
  localparam int DEF_MAX_SLS = 3;
  localparam int NCOMP = 6;
  localparam int WORD_W = 32;
  localparam int CFG_W = 54;
  localparam int NCOEF_REGS = 3;

  localparam logic [1:0] REQ_APPLY = 2'd0;
  localparam logic [1:0] REQ_UPDATE = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [2:0] CFG_DO_BULK = 3'd0;
  localparam logic [2:0] CFG_SLS_IN_USE = 3'd1;
  localparam logic [2:0] CFG_SLS0 = 3'd2;
  localparam logic [2:0] CFG_SLS1 = 3'd3;
  localparam logic [2:0] CFG_SLS2 = 3'd4;

  typedef logic signed [31:0] word_t;
  typedef logic signed [63:0] prod_t;
  typedef logic signed [65:0] wide_t;

  localparam wide_t MAX32 = 66'sd2147483647;
  localparam wide_t MIN32 = -66'sd2147483648;
  localparam wide_t DIV_BIAS = 66'sd12884901888;

  function automatic word_t sat32(input wide_t v);
    word_t r;
    if (v > MAX32) begin
      r = 32'sh7fffffff;
    end else if (v < MIN32) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // round half up, drop 15 or 16 fraction bits, saturate
  function automatic word_t rnd_sat(input wide_t v, input logic by15);
    wide_t t;
    if (by15) begin
      t = (v + 66'sd16384) >>> 15;
    end else begin
      t = (v + 66'sd32768) >>> 16;
    end
    return sat32(t);
  endfunction

  function automatic prod_t mul(input word_t a, input word_t b);
    prod_t r;
    r = a * b;
    return r;
  endfunction

  function automatic word_t coef_ext(input logic [CFG_W-1:0] c, input logic [1:0] which);
    logic [17:0] f;
    case (which)
      2'd0: f = c[17:0];
      2'd1: f = c[35:18];
      default: f = c[53:36];
    endcase
    return {{14{f[17]}}, f};
  endfunction
endpackage

// ----- hw/rtl/slsam_ram.sv -----
`timescale 1ns / 1ps
module slsam_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/sls_attenuation_memory_update.sv -----
// channel  signals                                          dir
// in       in_valid in_ready req_type slot in_c0..in_c5     in
//          bulk_change shear_change
// out      out_valid out_ready out_slot out_c0..out_c5      out
// cfg      cfg_valid cfg_ready cfg_index cfg_data           in
// one word at a time; the update, over the n mechanisms in use, is bound by six
// shared lane multipliers stepping through the mechanisms and a divide by three.
// after reset both memories are swept to zero, one slot a cycle,
// with in_ready low; cfg is always ready. a full output register stalls apply.
`timescale 1ns / 1ps
`include "sls_attenuation_memory_update_defines.svh"
module sls_attenuation_memory_update import slsam_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS,
  parameter int MAX_SLS = DEF_MAX_SLS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        req_type,
  input  logic [9:0]        slot,
  input  logic signed [31:0] in_c0,
  input  logic signed [31:0] in_c1,
  input  logic signed [31:0] in_c2,
  input  logic signed [31:0] in_c3,
  input  logic signed [31:0] in_c4,
  input  logic signed [31:0] in_c5,
  input  logic signed [31:0] bulk_change,
  input  logic signed [31:0] shear_change,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [9:0]        out_slot,
  output logic signed [31:0] out_c0,
  output logic signed [31:0] out_c1,
  output logic signed [31:0] out_c2,
  output logic signed [31:0] out_c3,
  output logic signed [31:0] out_c4,
  output logic signed [31:0] out_c5,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);
  localparam int AW = $clog2(SLOTS);
  localparam int ROW_MV = MAX_SLS * NCOMP * WORD_W;
  localparam int ROW_SR = NCOMP * WORD_W;
  localparam logic [AW:0] SLOTS_C = (AW + 1)'(SLOTS);
  localparam logic [1:0] MAX_SLS_C = 2'(MAX_SLS);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_MOD = 5'd1;
  localparam logic [4:0] S_RD = 5'd2;
  localparam logic [4:0] S_LD = 5'd3;
  localparam logic [4:0] S_AP0 = 5'd4;
  localparam logic [4:0] S_AP1 = 5'd5;
  localparam logic [4:0] S_OUT = 5'd6;
  localparam logic [4:0] S_DIV = 5'd7;
  localparam logic [4:0] S_DEV = 5'd8;
  localparam logic [4:0] S_SR0 = 5'd9;
  localparam logic [4:0] S_SR1 = 5'd10;
  localparam logic [4:0] S_SR2 = 5'd11;
  localparam logic [4:0] S_DK0 = 5'd12;
  localparam logic [4:0] S_DK1 = 5'd13;
  localparam logic [4:0] S_DK2 = 5'd14;
  localparam logic [4:0] S_DK3 = 5'd15;
  localparam logic [4:0] S_G0 = 5'd16;
  localparam logic [4:0] S_G1 = 5'd17;
  localparam logic [4:0] S_G2 = 5'd18;
  localparam logic [4:0] S_WR = 5'd19;
  localparam logic [4:0] S_CLR = 5'd20;

  logic [4:0]           state;
  logic [AW:0]          clr_cnt;
  logic                 clr_done;
  logic                 do_bulk;
  logic [1:0]           sls_in_use;
  logic [CFG_W-1:0]     sls_coefs [NCOEF_REGS];
  logic [1:0]           nsls;
  logic [1:0]           req;
  logic [9:0]           in_slot;
  logic [9:0]           slot_r;
  logic                 mstep;
  logic [AW-1:0]        addr;
  logic [26:0]          mod_next;
  word_t                cin [NCOMP];
  word_t                bulk;
  word_t                dmu;
  word_t                mv [MAX_SLS][NCOMP];
  word_t                mv_k [NCOMP];
  word_t                sro [NCOMP];
  word_t                srn [NCOMP];
  word_t                devv [NCOMP];
  word_t                sm;
  prod_t                p [NCOMP];
  prod_t                pb;
  wide_t                acc [NCOMP];
  wide_t                dstart;
  logic [1:0]           k;
  logic [CFG_W-1:0]     coef_sel;
  word_t                ca;
  word_t                cb;
  word_t                cg;
  logic [34:0]          du;
  logic [33:0]          dpart;
  logic [18:0]          dsum;
  logic                 dstep;
  logic [33:0]          dq;
  word_t                mean;
  word_t                oc [NCOMP];
  logic                 mem_we;
  logic [AW-1:0]        waddr;
  logic [ROW_MV-1:0]    mv_wdata;
  logic [ROW_MV-1:0]    mv_rdata;
  logic [ROW_SR-1:0]    sr_wdata;
  logic [ROW_SR-1:0]    sr_rdata;

  assign clr_done = (clr_cnt == SLOTS_C);
  assign in_ready = (state == S_IDLE) && clr_done;
  assign cfg_ready = 1'b1;
  assign nsls = (sls_in_use > MAX_SLS_C) ? MAX_SLS_C : sls_in_use;
  assign mean = dq[31:0];

  assign out_c0 = oc[0];
  assign out_c1 = oc[1];
  assign out_c2 = oc[2];
  assign out_c3 = oc[3];
  assign out_c4 = oc[4];
  assign out_c5 = oc[5];

  // memory port control
  assign mem_we = !clr_done || (state == S_WR) || (state == S_CLR);
  assign waddr = clr_done ? addr : clr_cnt[AW-1:0];

  always_comb begin
    mv_wdata = '0;
    sr_wdata = '0;
    if (state == S_WR) begin
      for (int kk = 0; kk < MAX_SLS; kk++) begin
        for (int l = 0; l < NCOMP; l++) begin
          mv_wdata[(kk*NCOMP+l)*WORD_W +: WORD_W] = mv[kk][l];
        end
      end
      for (int l = 0; l < NCOMP; l++) begin
        sr_wdata[l*WORD_W +: WORD_W] = srn[l];
      end
    end
  end

  slsam_ram #(.WIDTH(ROW_MV), .DEPTH(SLOTS)) u_mv_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (mv_wdata),
    .raddr (addr),
    .rdata (mv_rdata)
  );

  slsam_ram #(.WIDTH(ROW_SR), .DEPTH(SLOTS)) u_sr_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (sr_wdata),
    .raddr (addr),
    .rdata (sr_rdata)
  );

  // slot modulo SLOTS, five shifted subtracts per cycle
  always_comb begin
    logic [26:0] mr;
    int sh;
    mr = {17'd0, slot_r};
    for (int j = 0; j < 5; j++) begin
      sh = (mstep ? 4 : 9) - j;
      if (mr >= (27'(SLOTS) << sh)) begin
        mr = mr - (27'(SLOTS) << sh);
      end
    end
    mod_next = mr;
  end

  // selected mechanism
  always_comb begin
    for (int l = 0; l < NCOMP; l++) begin
      mv_k[l] = mv[0][l];
      for (int kk = 1; kk < MAX_SLS; kk++) begin
        if (k == 2'(kk)) begin
          mv_k[l] = mv[kk][l];
        end
      end
    end
    case (k)
      2'd0: coef_sel = sls_coefs[0];
      2'd1: coef_sel = sls_coefs[1];
      default: coef_sel = sls_coefs[2];
    endcase
    ca = coef_ext(coef_sel, 2'd0);
    cb = coef_ext(coef_sel, 2'd1);
    cg = coef_ext(coef_sel, 2'd2);
  end

  // biased sum plus one; its third is the mean, by a split reciprocal multiply
  assign dstart = 66'(cin[0]) + 66'(cin[1]) + 66'(cin[2]) + 66'sd1 + DIV_BIAS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      clr_cnt <= '0;
      do_bulk <= 1'b0;
      sls_in_use <= 2'd0;
      for (int i = 0; i < NCOEF_REGS; i++) begin
        sls_coefs[i] <= '0;
      end
      out_valid <= 1'b0;
    end else begin
      if (!clr_done) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DO_BULK: do_bulk <= cfg_data[0];
          CFG_SLS_IN_USE: sls_in_use <= cfg_data[1:0];
          CFG_SLS0: sls_coefs[0] <= cfg_data;
          CFG_SLS1: sls_coefs[1] <= cfg_data;
          CFG_SLS2: sls_coefs[2] <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req <= req_type;
            in_slot <= slot;
            slot_r <= slot;
            mstep <= 1'b0;
            cin[0] <= in_c0;
            cin[1] <= in_c1;
            cin[2] <= in_c2;
            cin[3] <= in_c3;
            cin[4] <= in_c4;
            cin[5] <= in_c5;
            bulk <= bulk_change;
            dmu <= shear_change;
            if (req_type == REQ_APPLY || req_type == REQ_UPDATE || req_type == REQ_CLEAR) begin
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          slot_r <= mod_next[9:0];
          mstep <= 1'b1;
          if (mstep) begin
            addr <= mod_next[AW-1:0];
            state <= (req == REQ_CLEAR) ? S_CLR : S_RD;
          end
        end
        S_RD: state <= S_LD;
        S_LD: begin
          for (int kk = 0; kk < MAX_SLS; kk++) begin
            for (int l = 0; l < NCOMP; l++) begin
              mv[kk][l] <= mv_rdata[(kk*NCOMP+l)*WORD_W +: WORD_W];
            end
          end
          for (int l = 0; l < NCOMP; l++) begin
            sro[l] <= sr_rdata[l*WORD_W +: WORD_W];
          end
          k <= 2'd0;
          du <= dstart[34:0];
          dstep <= 1'b0;
          state <= (req == REQ_UPDATE) ? S_DIV : S_AP0;
        end
        S_AP0: begin
          for (int l = 0; l < NCOMP; l++) begin
            acc[l] <= 66'(cin[l]);
          end
          state <= S_AP1;
        end
        S_AP1: begin
          if (k == nsls) begin
            state <= S_OUT;
          end else begin
            for (int l = 0; l < NCOMP; l++) begin
              acc[l] <= acc[l] - 66'(mv_k[l]);
            end
            k <= k + 2'd1;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_slot <= in_slot;
            for (int l = 0; l < NCOMP; l++) begin
              oc[l] <= sat32(acc[l]);
            end
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          dstep <= 1'b1;
          if (!dstep) begin
            // 2^18 is 3 * 87381 + 1
            dpart <= 34'(du[34:18]) * 34'd87381;
            dsum <= 19'(du[34:18]) + 19'(du[17:0]);
          end else begin
            dq <= dpart + 34'(({21'd0, dsum} * 40'd699051) >> 21);
            state <= S_DEV;
          end
        end
        S_DEV: begin
          for (int l = 0; l < NCOMP; l++) begin
            devv[l] <= (l < 3) ? sat32(66'(cin[l]) - 66'(mean)) : cin[l];
          end
          state <= S_SR0;
        end
        S_SR0: begin
          for (int l = 0; l < NCOMP; l++) begin
            p[l] <= mul(dmu, devv[l]);
          end
          pb <= mul(bulk, mean);
          state <= S_SR1;
        end
        S_SR1: begin
          for (int l = 0; l < NCOMP; l++) begin
            srn[l] <= rnd_sat(66'(p[l]), (l < 3));
          end
          sm <= rnd_sat(66'(pb), 1'b0);
          state <= S_SR2;
        end
        S_SR2: begin
          if (do_bulk) begin
            for (int l = 0; l < 3; l++) begin
              srn[l] <= sat32(66'(srn[l]) + 66'(sm));
            end
          end else begin
            srn[2] <= sat32(-(66'(srn[0]) + 66'(srn[1])));
          end
          k <= 2'd0;
          state <= S_DK0;
        end
        S_DK0: begin
          if (k == nsls) begin
            k <= 2'd0;
            state <= S_G0;
          end else begin
            for (int l = 0; l < NCOMP; l++) begin
              p[l] <= mul(ca, mv_k[l]);
            end
            state <= S_DK1;
          end
        end
        S_DK1: begin
          for (int l = 0; l < NCOMP; l++) begin
            acc[l] <= 66'(p[l]);
            p[l] <= mul(cb, sro[l]);
          end
          state <= S_DK2;
        end
        S_DK2: begin
          for (int l = 0; l < NCOMP; l++) begin
            acc[l] <= acc[l] + 66'(p[l]);
          end
          state <= S_DK3;
        end
        S_DK3: begin
          for (int kk = 0; kk < MAX_SLS; kk++) begin
            if (k == 2'(kk)) begin
              for (int l = 0; l < NCOMP; l++) begin
                mv[kk][l] <= rnd_sat(acc[l], 1'b0);
              end
            end
          end
          k <= k + 2'd1;
          state <= S_DK0;
        end
        S_G0: begin
          if (k == nsls) begin
            state <= S_WR;
          end else begin
            for (int l = 0; l < NCOMP; l++) begin
              p[l] <= mul(cg, srn[l]);
            end
            state <= S_G1;
          end
        end
        S_G1: begin
          for (int l = 0; l < NCOMP; l++) begin
            acc[l] <= (66'(mv_k[l]) <<< 16) + 66'(p[l]);
          end
          state <= S_G2;
        end
        S_G2: begin
          for (int kk = 0; kk < MAX_SLS; kk++) begin
            if (k == 2'(kk)) begin
              for (int l = 0; l < NCOMP; l++) begin
                mv[kk][l] <= rnd_sat(acc[l], 1'b0);
              end
            end
          end
          k <= k + 2'd1;
          state <= S_G0;
        end
        S_WR: state <= S_IDLE;
        S_CLR: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `SLSAM_ASSERT_IMPL(a_k_bound, clk, rst, (state == S_DK0 || state == S_G0 || state == S_AP1), (k <= nsls))
  `SLSAM_ASSERT_NEXT(a_sweep_stays_done, clk, rst, clr_done, clr_done)
  `SLSAM_ASSERT_NEXT(a_out_load, clk, rst, (state == S_OUT && (!out_valid || out_ready)), (out_valid && state == S_IDLE))
endmodule
